// ===== src/addressed_message_mailbox_assert.svh =====
// Assertion macros shared by the mailbox RTL files.
// Each macro expects clk and a synchronous active-low rst_n in scope.
`ifndef ADDRESSED_MESSAGE_MAILBOX_ASSERT_SVH
`define ADDRESSED_MESSAGE_MAILBOX_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MAM_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mailbox assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define MAM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mailbox assertion failed");

`endif

// ===== src/mam_pkg.sv =====
// Package for the addressed message mailbox: sizes, command codes and
// the packed transfer types. No dependencies.
`timescale 1ns / 1ps

package mam_pkg;

  localparam int SLOT_COUNT    = 8;
  localparam int PAYLOAD_BYTES = 4;

  localparam int CMD_W     = 2;
  localparam int ID_W      = 8;
  localparam int CODE_W    = 8;
  localparam int PAYLOAD_W = 32;

  // Only the low PAYLOAD_BYTES bytes of a payload are kept in a slot.
  localparam int SLOT_PAY_W = (PAYLOAD_BYTES * 8 >= PAYLOAD_W) ? PAYLOAD_W
                                                               : PAYLOAD_BYTES * 8;
  localparam int SLOT_IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [ID_W-1:0] EMPTY_ID_RESET = '0;

  localparam logic [CMD_W-1:0] CMD_SEND  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RECV  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  typedef enum logic [1:0] {
    OP_SEND,
    OP_RECV,
    OP_CLEAR,
    OP_NONE
  } mam_op_t;

  typedef struct packed {
    logic [CMD_W-1:0]     command;
    logic [ID_W-1:0]      dest_id;
    logic [ID_W-1:0]      source_id;
    logic [CODE_W-1:0]    message_code;
    logic [PAYLOAD_W-1:0] payload_in;
  } mam_in_t;

  typedef struct packed {
    logic                 ok;
    logic [ID_W-1:0]      dest_out;
    logic [ID_W-1:0]      source_out;
    logic [CODE_W-1:0]    code_out;
    logic [PAYLOAD_W-1:0] payload_out;
  } mam_out_t;

  // Classified command as it waits in the queue between front and back.
  typedef struct packed {
    mam_op_t               op;
    logic [ID_W-1:0]       dest_id;
    logic [ID_W-1:0]       source_id;
    logic [CODE_W-1:0]     message_code;
    logic [SLOT_PAY_W-1:0] payload;
  } mam_entry_t;

endpackage

// ===== src/mam_front.sv =====
// Mailbox front end: decodes the command and trims the payload.
// Depends on mam_pkg.
`timescale 1ns / 1ps

module mam_front (
  input  logic                in_valid,
  output logic                in_ready,
  input  mam_pkg::mam_in_t    in_data,
  output logic                push_valid,
  input  logic                push_ready,
  output mam_pkg::mam_entry_t push_data
);

  always_comb begin
    push_data.dest_id      = in_data.dest_id;
    push_data.source_id    = in_data.source_id;
    push_data.message_code = in_data.message_code;
    push_data.payload      = in_data.payload_in[mam_pkg::SLOT_PAY_W-1:0];
    case (in_data.command)
      mam_pkg::CMD_SEND:  push_data.op = mam_pkg::OP_SEND;
      mam_pkg::CMD_RECV:  push_data.op = mam_pkg::OP_RECV;
      mam_pkg::CMD_CLEAR: push_data.op = mam_pkg::OP_CLEAR;
      default:            push_data.op = mam_pkg::OP_NONE;
    endcase
  end

  assign push_valid = in_valid;
  assign in_ready   = push_ready;

endmodule

// ===== src/mam_queue.sv =====
// Short FIFO of classified commands between the mailbox front and back.
// Depends on mam_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "addressed_message_mailbox_assert.svh"

module mam_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  output logic                push_ready,
  input  mam_pkg::mam_entry_t push_data,
  output logic                pop_valid,
  input  logic                pop_ready,
  output mam_pkg::mam_entry_t pop_data
);

  mam_pkg::mam_entry_t                  mem_r [mam_pkg::QUEUE_DEPTH];
  logic [mam_pkg::QUEUE_PTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [mam_pkg::QUEUE_PTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [mam_pkg::QUEUE_CNT_W-1:0]      count_r, count_nxt;
  logic                                 push_fire;
  logic                                 pop_fire;

  assign push_ready = (count_r != mam_pkg::QUEUE_CNT_W'(mam_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_fire) begin
      wr_ptr_nxt = (wr_ptr_r == mam_pkg::QUEUE_PTR_W'(mam_pkg::QUEUE_DEPTH - 1)) ? '0
                   : wr_ptr_r + mam_pkg::QUEUE_PTR_W'(1);
    end
    if (pop_fire) begin
      rd_ptr_nxt = (rd_ptr_r == mam_pkg::QUEUE_PTR_W'(mam_pkg::QUEUE_DEPTH - 1)) ? '0
                   : rd_ptr_r + mam_pkg::QUEUE_PTR_W'(1);
    end
    case ({push_fire, pop_fire})
      2'b10:   count_nxt = count_r + mam_pkg::QUEUE_CNT_W'(1);
      2'b01:   count_nxt = count_r - mam_pkg::QUEUE_CNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_fire) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  `MAM_ASSERT_SAME(a_count_bound, 1'b1,
                   count_r <= mam_pkg::QUEUE_CNT_W'(mam_pkg::QUEUE_DEPTH))
  `MAM_ASSERT_NEXT(a_push_only_grows, push_fire && !pop_fire,
                   count_r == $past(count_r) + mam_pkg::QUEUE_CNT_W'(1))

endmodule

// ===== src/mam_back.sv =====
// Mailbox back end: slot table, free marker register, parallel slot search
// and the result register. Depends on mam_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "addressed_message_mailbox_assert.svh"

module mam_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [mam_pkg::ID_W-1:0]        cfg_wdata,
  input  logic                            pop_valid,
  output logic                            pop_ready,
  input  mam_pkg::mam_entry_t             pop_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output mam_pkg::mam_out_t               out_data
);

  logic [mam_pkg::ID_W-1:0]       empty_id_r;
  logic [mam_pkg::ID_W-1:0]       slot_dest_r     [mam_pkg::SLOT_COUNT];
  logic [mam_pkg::ID_W-1:0]       slot_dest_nxt   [mam_pkg::SLOT_COUNT];
  logic [mam_pkg::ID_W-1:0]       slot_source_r   [mam_pkg::SLOT_COUNT];
  logic [mam_pkg::ID_W-1:0]       slot_source_nxt [mam_pkg::SLOT_COUNT];
  logic [mam_pkg::CODE_W-1:0]     slot_code_r     [mam_pkg::SLOT_COUNT];
  logic [mam_pkg::CODE_W-1:0]     slot_code_nxt   [mam_pkg::SLOT_COUNT];
  logic [mam_pkg::SLOT_PAY_W-1:0] slot_pay_r      [mam_pkg::SLOT_COUNT];
  logic [mam_pkg::SLOT_PAY_W-1:0] slot_pay_nxt    [mam_pkg::SLOT_COUNT];

  logic [mam_pkg::SLOT_COUNT-1:0] free_vec;
  logic [mam_pkg::SLOT_COUNT-1:0] match_vec;
  logic [mam_pkg::SLOT_COUNT-1:0] sel_vec;
  logic [mam_pkg::SLOT_IDX_W-1:0] hit_idx;
  logic                           hit;
  logic                           fire;
  logic                           out_valid_r;
  mam_pkg::mam_out_t              out_data_r;
  mam_pkg::mam_out_t              res;

  assign fire      = pop_valid && (!out_valid_r || out_ready);
  assign pop_ready = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Compare every slot at once, then take the lowest candidate.
  always_comb begin
    for (int i = 0; i < mam_pkg::SLOT_COUNT; i++) begin
      free_vec[i]  = (slot_dest_r[i] == empty_id_r);
      match_vec[i] = (slot_dest_r[i] == pop_data.dest_id);
    end
    sel_vec = (pop_data.op == mam_pkg::OP_SEND) ? free_vec : match_vec;
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = mam_pkg::SLOT_COUNT - 1; i >= 0; i--) begin
      if (sel_vec[i]) begin
        hit     = 1'b1;
        hit_idx = mam_pkg::SLOT_IDX_W'(i);
      end
    end
  end

  always_comb begin
    slot_dest_nxt   = slot_dest_r;
    slot_source_nxt = slot_source_r;
    slot_code_nxt   = slot_code_r;
    slot_pay_nxt    = slot_pay_r;
    res             = '0;
    if (fire) begin
      case (pop_data.op)
        mam_pkg::OP_SEND: begin
          if (hit) begin
            slot_dest_nxt[hit_idx]   = pop_data.dest_id;
            slot_source_nxt[hit_idx] = pop_data.source_id;
            slot_code_nxt[hit_idx]   = pop_data.message_code;
            slot_pay_nxt[hit_idx]    = pop_data.payload;
            res.ok                   = 1'b1;
          end else begin
            // A full mailbox is flushed and the message is dropped.
            for (int i = 0; i < mam_pkg::SLOT_COUNT; i++) begin
              slot_dest_nxt[i]   = empty_id_r;
              slot_source_nxt[i] = empty_id_r;
              slot_pay_nxt[i]    = '0;
            end
          end
        end
        mam_pkg::OP_RECV: begin
          if (hit) begin
            res.ok                   = 1'b1;
            res.dest_out             = slot_dest_r[hit_idx];
            res.source_out           = slot_source_r[hit_idx];
            res.code_out             = slot_code_r[hit_idx];
            res.payload_out          = mam_pkg::PAYLOAD_W'(slot_pay_r[hit_idx]);
            slot_dest_nxt[hit_idx]   = empty_id_r;
            slot_source_nxt[hit_idx] = empty_id_r;
            slot_code_nxt[hit_idx]   = empty_id_r;
            slot_pay_nxt[hit_idx]    = '0;
          end
        end
        mam_pkg::OP_CLEAR: begin
          // The code fields survive a mailbox clear.
          for (int i = 0; i < mam_pkg::SLOT_COUNT; i++) begin
            slot_dest_nxt[i]   = empty_id_r;
            slot_source_nxt[i] = empty_id_r;
            slot_pay_nxt[i]    = '0;
          end
          res.ok = 1'b1;
        end
        default: begin
          res = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      empty_id_r  <= mam_pkg::EMPTY_ID_RESET;
      out_valid_r <= 1'b0;
      for (int i = 0; i < mam_pkg::SLOT_COUNT; i++) begin
        slot_dest_r[i]   <= mam_pkg::EMPTY_ID_RESET;
        slot_source_r[i] <= mam_pkg::EMPTY_ID_RESET;
        slot_code_r[i]   <= '0;
        slot_pay_r[i]    <= '0;
      end
    end else begin
      if (cfg_we) begin
        empty_id_r <= cfg_wdata;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      slot_dest_r   <= slot_dest_nxt;
      slot_source_r <= slot_source_nxt;
      slot_code_r   <= slot_code_nxt;
      slot_pay_r    <= slot_pay_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= res;
    end
  end

  `MAM_ASSERT_NEXT(a_clear_frees_all, fire && pop_data.op == mam_pkg::OP_CLEAR && !cfg_we,
                   &free_vec)
  `MAM_ASSERT_NEXT(a_recv_dest_matches, fire && pop_data.op == mam_pkg::OP_RECV && hit,
                   out_data_r.ok && out_data_r.dest_out == $past(pop_data.dest_id))
  `MAM_ASSERT_SAME(a_fail_is_zero, out_valid_r && !out_data_r.ok,
                   out_data_r.dest_out == '0 && out_data_r.source_out == '0 &&
                   out_data_r.code_out == '0 && out_data_r.payload_out == '0)

endmodule

// ===== src/addressed_message_mailbox.sv =====
// Top level of the addressed message mailbox: front end, command queue and
// slot table back end. Depends on mam_pkg, mam_front, mam_queue, mam_back.
`timescale 1ns / 1ps

//  Channel  | Handshake           | Payload
//  ---------+---------------------+---------------------------------------
//  input    | in_valid / in_ready | in_data   (mam_pkg::mam_in_t)
//  result   | out_valid/out_ready | out_data  (mam_pkg::mam_out_t)
//  config   | cfg_we              | cfg_wdata (free marker, empty_id)
//
// A command reaches the result register by way of the command queue: its
// transfer places it in the queue, and once the back end can accept it the
// slot search and write-back load the result register. With results taken promptly
// the back end retires one command per cycle, so one transfer per cycle is sustained.
// Synchronous reset empties every slot at once; no clearing pass follows.
// A stalled result holds the back end; the two-entry queue then fills and in_ready drops.

module addressed_message_mailbox (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  mam_pkg::mam_in_t         in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output mam_pkg::mam_out_t        out_data,
  input  logic                     cfg_we,
  input  logic [mam_pkg::ID_W-1:0] cfg_wdata
);

  // Front end to queue.
  logic                push_valid;
  logic                push_ready;
  mam_pkg::mam_entry_t push_data;

  // Queue to back end.
  logic                pop_valid;
  logic                pop_ready;
  mam_pkg::mam_entry_t pop_data;

  // The front end only decodes and trims; it never stalls on its own.
  mam_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // The queue decouples the input transfer from the slot table update.
  mam_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // The back end owns the slots, the free marker and the result register.
  mam_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
